// ===== rtl/idpt_pkg.sv =====
// Shared types, constants and helpers for the id pair table.
package idpt_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int ID_W          = 32;
    localparam int PAIR_W        = 2 * ID_W;
    localparam int ACT_W         = 2;
    localparam int STATUS_W      = 3;
    localparam int IDX_OUT_W     = 6;
    localparam int CNT_OUT_W     = 7;

    typedef enum logic [ACT_W-1:0] {
        ACT_LOOKUP = 2'd0,
        ACT_ADD    = 2'd1,
        ACT_DELETE = 2'd2
    } act_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND    = 3'd0,
        ST_ADDED    = 3'd1,
        ST_DELETED  = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT,
        S_RESULT
    } state_t;

    // True when either half of the stored pair equals the id.
    function automatic logic holds(input logic [PAIR_W-1:0] w, input logic [ID_W-1:0] id);
        return (w[ID_W-1:0] == id) || (w[PAIR_W-1:ID_W] == id);
    endfunction

endpackage

// ===== rtl/id_pair_table.sv =====
// Top level of the id pair table: scan sequencer, compare unit and result register.
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_stall  | action, id_a, id_b
//  out     | output    | out_valid / out_stall | status, entry_index, live_count
//
// Lookup and add scan the live entries through the single RAM read port, then load the result.
// A delete that hits also moves the later entries down, one entry read and written back per step.
// One request is in work at a time; the next is accepted in the cycle after its result is loaded.
// Reset clears the live count and the control state; the table RAM is not cleared.
// A stalled result holds in the output register; the next request can be accepted meanwhile.
module id_pair_table
    import idpt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [ACT_W-1:0]            action,
    input  logic signed [ID_W-1:0]      id_a,
    input  logic signed [ID_W-1:0]      id_b,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [STATUS_W-1:0]         status,
    output logic [IDX_OUT_W-1:0]        entry_index,
    output logic [CNT_OUT_W-1:0]        live_count
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    state_t            state_reg, state_next;
    logic [ACT_W-1:0]  act_reg, act_next;
    logic [ID_W-1:0]   key_a_reg, key_a_next;
    logic [ID_W-1:0]   key_b_reg, key_b_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic              cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic              hit_reg, hit_next;
    logic [IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    logic              wr_pend_reg, wr_pend_next;
    logic [IDX_W-1:0]  sh_addr_reg, sh_addr_next;
    status_t           res_status_reg, res_status_next;
    logic [IDX_W-1:0]  res_idx_reg, res_idx_next;
    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg, out_status_next;
    logic [IDX_OUT_W-1:0] out_index_reg, out_index_next;
    logic [CNT_OUT_W-1:0] out_count_reg, out_count_next;

    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [PAIR_W-1:0] rd_data;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [PAIR_W-1:0] wr_data;

    logic              in_xfer;
    logic              out_free;
    logic              more_to_read;
    logic              match;
    logic              has_room;
    logic              add_ok;

    assign in_xfer      = in_valid && !in_stall;
    assign out_free     = !out_valid_reg || !out_stall;
    assign more_to_read = ptr_reg < count_reg;
    assign has_room     = count_reg < CNT_W'(TABLE_DEPTH);
    assign match        = cmp_vld_reg && (holds(rd_data, key_a_reg) || holds(rd_data, key_b_reg));
    assign add_ok       = (state_reg == S_DECIDE) && (act_reg == ACT_ADD) && !hit_reg && has_room;

    idpt_ram #(
        .WIDTH (PAIR_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Read port: one entry per cycle while scanning or shifting.
    assign rd_en   = ((state_reg == S_SCAN) || (state_reg == S_SHIFT)) && more_to_read;
    assign rd_addr = ptr_reg[IDX_W-1:0];

    // Write port: moved entry during a shift, or the appended pair.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = sh_addr_reg;
        wr_data = rd_data;
        if (wr_pend_reg)
        begin
            wr_en = 1'b1;
        end
        else if (add_ok)
        begin
            wr_en   = 1'b1;
            wr_addr = count_reg[IDX_W-1:0];
            wr_data = {key_b_reg, key_a_reg};
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!more_to_read && !cmp_vld_reg)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if ((act_reg == ACT_DELETE) && hit_reg)
                begin
                    state_next = S_SHIFT;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end
            S_SHIFT:
            begin
                if (!more_to_read && !wr_pend_reg)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        act_next        = act_reg;
        key_a_next      = key_a_reg;
        key_b_next      = key_b_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        wr_pend_next    = 1'b0;
        sh_addr_next    = sh_addr_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        out_count_next  = out_count_reg;
        in_stall        = (state_reg != S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                act_next   = action;
                key_a_next = id_a;
                // Lookup and delete search on one id only.
                key_b_next = (action == ACT_ADD) ? id_b : id_a;
                ptr_next   = '0;
                hit_next   = 1'b0;
            end
            S_SCAN:
            begin
                if (more_to_read)
                begin
                    ptr_next     = ptr_reg + CNT_W'(1);
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = ptr_reg[IDX_W-1:0];
                end
                if (match)
                begin
                    hit_next = 1'b1;
                    // Delete keeps the last hit; the others keep the first.
                    if ((act_reg == ACT_DELETE) || !hit_reg)
                    begin
                        hit_idx_next = cmp_idx_reg;
                    end
                end
            end
            S_DECIDE:
            begin
                res_status_next = ST_NOTFOUND;
                res_idx_next    = '0;
                ptr_next        = CNT_W'(hit_idx_reg) + CNT_W'(1);
                case (act_reg)
                    ACT_LOOKUP:
                    begin
                        if (hit_reg)
                        begin
                            res_status_next = ST_FOUND;
                            res_idx_next    = hit_idx_reg;
                        end
                    end
                    ACT_ADD:
                    begin
                        if (hit_reg)
                        begin
                            res_status_next = ST_FOUND;
                            res_idx_next    = hit_idx_reg;
                        end
                        else if (!has_room)
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            res_status_next = ST_ADDED;
                            res_idx_next    = count_reg[IDX_W-1:0];
                            count_next      = count_reg + CNT_W'(1);
                        end
                    end
                    ACT_DELETE:
                    begin
                        if (hit_reg)
                        begin
                            res_status_next = ST_DELETED;
                            res_idx_next    = hit_idx_reg;
                        end
                    end
                    default:
                    begin
                        res_status_next = ST_NOTFOUND;
                    end
                endcase
            end
            S_SHIFT:
            begin
                // Read entry k, write it to k-1 on the next cycle.
                if (more_to_read)
                begin
                    ptr_next     = ptr_reg + CNT_W'(1);
                    wr_pend_next = 1'b1;
                    sh_addr_next = IDX_W'(ptr_reg - CNT_W'(1));
                end
                else if (!wr_pend_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_index_next  = IDX_OUT_W'(res_idx_reg);
                    out_count_next  = CNT_OUT_W'(count_reg);
                end
            end
            default:
            begin
                hit_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cmp_vld_reg   <= 1'b0;
            wr_pend_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_vld_reg   <= cmp_vld_next;
            wr_pend_reg   <= wr_pend_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        key_a_reg      <= key_a_next;
        key_b_reg      <= key_b_next;
        ptr_reg        <= ptr_next;
        cmp_idx_reg    <= cmp_idx_next;
        hit_idx_reg    <= hit_idx_next;
        sh_addr_reg    <= sh_addr_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
        out_count_reg  <= out_count_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign entry_index = out_index_reg;
    assign live_count  = out_count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("live count above table depth");

    a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ((out_status_reg == ST_NOTFOUND) || (out_status_reg == ST_FULL)))
        |-> (out_index_reg == '0))
        else $error("non-zero index on a miss");

    a_added_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == ST_ADDED))
        |-> (out_index_reg == IDX_OUT_W'(out_count_reg - CNT_OUT_W'(1))))
        else $error("added entry is not the last live entry");

    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_pend_reg |-> ((CNT_W'(sh_addr_reg) + CNT_W'(1)) < count_reg))
        else $error("shift writes outside the live range");

endmodule

// ===== rtl/idpt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module idpt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== sim/idpt_tb_pkg.sv =====
`timescale 1ns / 100ps
// Scoreboard for the id pair table bench: a mirror of the table and the queue of awaited results.
package idpt_tb_pkg;

    import idpt_pkg::*;

    // The action field is two bits wide; the block must treat this spare code as a miss.
    localparam logic [ACT_W-1:0] ACT_UNUSED       = 2'd3;
    localparam int               MIRROR_DEPTH     = DEPTH_DEFAULT;
    localparam int unsigned      SHOWN_MISMATCHES = 40;

    typedef struct packed {
        status_t              status;
        logic [IDX_OUT_W-1:0] index;
        logic [CNT_OUT_W-1:0] count;
    } table_result_t;

    class pair_table_checker;

        logic [PAIR_W-1:0] pairs [MIRROR_DEPTH];
        int unsigned       live;
        table_result_t     awaited [$];
        int unsigned       mismatches;
        int unsigned       results_seen;

        function new();
            live         = 0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function bit slot_holds(int slot, logic [ID_W-1:0] id);
            return (pairs[slot][ID_W-1:0] == id) || (pairs[slot][PAIR_W-1:ID_W] == id);
        endfunction

        function int first_holding(logic [ID_W-1:0] a, logic [ID_W-1:0] b);
            for (int i = 0; i < live; i++)
            begin
                if (slot_holds(i, a) || slot_holds(i, b))
                    return i;
            end
            return -1;
        endfunction

        // Apply one accepted request to the mirror and queue the result it must give.
        function void note_request(logic [ACT_W-1:0] act, logic [ID_W-1:0] a,
                                   logic [ID_W-1:0] b);
            table_result_t r;
            int            hit;
            r.status = ST_NOTFOUND;
            r.index  = '0;
            hit      = -1;
            case (act)
                ACT_LOOKUP:
                begin
                    hit = first_holding(a, a);
                    if (hit >= 0)
                    begin
                        r.status = ST_FOUND;
                        r.index  = IDX_OUT_W'(hit);
                    end
                end
                ACT_ADD:
                begin
                    hit = first_holding(a, b);
                    if (hit >= 0)
                    begin
                        r.status = ST_FOUND;
                        r.index  = IDX_OUT_W'(hit);
                    end
                    else if (live >= MIRROR_DEPTH)
                        r.status = ST_FULL;
                    else
                    begin
                        pairs[live] = {b, a};
                        r.index     = IDX_OUT_W'(live);
                        r.status    = ST_ADDED;
                        live++;
                    end
                end
                ACT_DELETE:
                begin
                    // the last holder goes; later entries close the gap
                    for (int i = 0; i < live; i++)
                    begin
                        if (slot_holds(i, a))
                            hit = i;
                    end
                    if (hit >= 0)
                    begin
                        for (int i = hit; i + 1 < live; i++)
                            pairs[i] = pairs[i + 1];
                        pairs[live - 1] = '0;
                        live--;
                        r.status = ST_DELETED;
                        r.index  = IDX_OUT_W'(hit);
                    end
                end
                default:
                    r.status = ST_NOTFOUND;
            endcase
            r.count = CNT_OUT_W'(live);
            awaited.push_back(r);
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= SHOWN_MISMATCHES)
                $display("mismatch: %s", what);
        endtask

        task check_result(logic [STATUS_W-1:0] st, logic [IDX_OUT_W-1:0] idx,
                          logic [CNT_OUT_W-1:0] cnt);
            table_result_t want;
            results_seen++;
            if (awaited.size() == 0)
            begin
                report($sformatf("result %0d arrived with none awaited", results_seen));
                return;
            end
            want = awaited.pop_front();
            if (st !== want.status)
                report($sformatf("result %0d status %0d, expected %0d",
                                 results_seen, st, want.status));
            if (idx !== want.index)
                report($sformatf("result %0d entry_index %0d, expected %0d",
                                 results_seen, idx, want.index));
            if (cnt !== want.count)
                report($sformatf("result %0d live_count %0d, expected %0d",
                                 results_seen, cnt, want.count));
        endtask

        function int unsigned pending();
            return awaited.size();
        endfunction

        function int unsigned live_entries();
            return live;
        endfunction

        // Either half of a random live entry, for requests that should hit.
        function logic [ID_W-1:0] any_live_id();
            int unsigned slot;
            slot = $urandom_range(live - 1);
            return ($urandom_range(1) != 0) ? pairs[slot][PAIR_W-1:ID_W] : pairs[slot][ID_W-1:0];
        endfunction

    endclass

endpackage

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the id pair table: request driver, result monitor and run control.
module tb;

    import idpt_pkg::*;
    import idpt_tb_pkg::*;

    localparam int PHASE_ITEMS    = 250;
    localparam int MODE_ITEMS     = 150;
    localparam int MAX_GAP        = 20;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 200;

    typedef enum int {
        MIX_FILL  = 0,
        MIX_BOTH  = 1,
        MIX_DRAIN = 2
    } request_mix_t;

    logic                    clk         = 1'b0;
    logic                    rst_n       = 1'b0;
    logic                    in_valid    = 1'b0;
    logic                    in_stall;
    logic [ACT_W-1:0]        action      = '0;
    logic signed [ID_W-1:0]  id_a        = '0;
    logic signed [ID_W-1:0]  id_b        = '0;
    logic                    out_valid;
    logic                    out_stall   = 1'b0;
    logic [STATUS_W-1:0]     status;
    logic [IDX_OUT_W-1:0]    entry_index;
    logic [CNT_OUT_W-1:0]    live_count;

    int unsigned             send_idle_pct  = 0;
    int unsigned             recv_stall_pct = 0;
    logic                    hold_on        = 1'b0;
    logic                    holdoff_go     = 1'b0;

    pair_table_checker       table_chk = new();

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    id_pair_table #(
        .TABLE_DEPTH (DEPTH_DEFAULT)
    ) i_dut (.*);

    // Check each result transfer and choose the stall for the next cycle.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            table_chk.check_result(status, entry_index, live_count);
        out_stall <= hold_on || ($urandom_range(99) < recv_stall_pct);
    end

    // Long hold-off on the result side so the block backs up onto its input.
    initial
    begin
        @(posedge holdoff_go);
        hold_on <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
    end

    task send_request(input logic [ACT_W-1:0] act, input logic [ID_W-1:0] a,
                      input logic [ID_W-1:0] b);
        int unsigned gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        id_a     <= a;
        id_b     <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        table_chk.note_request(act, a, b);
    endtask

    function logic [ID_W-1:0] corner_id();
        case ($urandom_range(4))
            0:       return 32'h0000_0000;
            1:       return 32'h0000_0001;
            2:       return 32'h7fff_ffff;
            3:       return 32'h8000_0000;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    function logic [ID_W-1:0] pick_id(int unsigned live_pct);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < live_pct && table_chk.live_entries() != 0)
            return table_chk.any_live_id();
        if (roll < live_pct + 5)
            return corner_id();
        return $urandom();
    endfunction

    // The mix drifts between filling, balanced and draining so the table runs full and empty.
    task random_request(input int unsigned n);
        int unsigned      roll;
        logic [ACT_W-1:0] act;
        logic [ID_W-1:0]  a;
        logic [ID_W-1:0]  b;
        roll = $urandom_range(99);
        case ((n / MODE_ITEMS) % 3)
            MIX_FILL:
                act = (roll < 75) ? ACT_ADD : (roll < 88) ? ACT_LOOKUP :
                      (roll < 96) ? ACT_DELETE : ACT_UNUSED;
            MIX_BOTH:
                act = (roll < 30) ? ACT_ADD : (roll < 60) ? ACT_LOOKUP :
                      (roll < 95) ? ACT_DELETE : ACT_UNUSED;
            default:
                act = (roll < 12) ? ACT_ADD : (roll < 35) ? ACT_LOOKUP :
                      (roll < 95) ? ACT_DELETE : ACT_UNUSED;
        endcase
        if (act == ACT_ADD)
        begin
            a = pick_id(15);
            b = pick_id(15);
        end
        else
        begin
            a = pick_id(80);
            b = $urandom();
        end
        send_request(act, a, b);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table: every action misses; then three adds, and lookups that hit and miss
        send_request(ACT_LOOKUP, 32'h8000_0000, 32'h0000_0000);
        send_request(ACT_DELETE, 32'h0000_0000, 32'hffff_ffff);
        send_request(ACT_UNUSED, 32'h0000_0000, 32'h0000_0000);
        send_request(ACT_ADD,    32'h8000_0000, 32'h7fff_ffff);
        send_request(ACT_ADD,    32'h0000_0000, 32'hffff_ffff);
        send_request(ACT_ADD,    32'h5a5a_5a5a, 32'h5a5a_5a5a);
        send_request(ACT_LOOKUP, 32'h7fff_ffff, 32'h8000_0000);
        send_request(ACT_LOOKUP, 32'h0000_0000, 32'h0000_0001);
        send_request(ACT_LOOKUP, 32'h0000_0001, 32'h0000_0000);
        // add hits through the second id, then through the first
        send_request(ACT_ADD,    32'h1234_5678, 32'hffff_ffff);
        send_request(ACT_ADD,    32'h7fff_ffff, 32'h0000_0002);
        send_request(ACT_UNUSED, 32'h5a5a_5a5a, 32'h0000_0000);
        send_request(ACT_DELETE, 32'h0000_0001, 32'h0000_0000);
        // drop the first entry and shift the rest down, then drop the tail
        send_request(ACT_DELETE, 32'h8000_0000, 32'h0000_0000);
        send_request(ACT_LOOKUP, 32'h5a5a_5a5a, 32'hffff_ffff);
        send_request(ACT_DELETE, 32'h5a5a_5a5a, 32'h0000_0000);
        send_request(ACT_DELETE, 32'hffff_ffff, 32'h0000_0000);
        send_request(ACT_ADD,    32'hffff_ffff, 32'h0000_0000);

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    send_idle_pct   = 0;
                    recv_stall_pct <= 0;
                end
                1:
                begin
                    send_idle_pct   = 59;
                    recv_stall_pct <= 0;
                end
                2:
                begin
                    send_idle_pct   = 0;
                    recv_stall_pct <= 59;
                    holdoff_go      = 1'b1;
                end
                default:
                begin
                    send_idle_pct   = 19;
                    recv_stall_pct <= 19;
                end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++)
                random_request(p * PHASE_ITEMS + k);
        end
        in_valid <= 1'b0;

        while (table_chk.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (table_chk.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #8ms;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/idpt_pkg.sv
rtl/idpt_ram.sv
rtl/id_pair_table.sv
sim/idpt_tb_pkg.sv
sim/tb.sv
